@@ hw/rtl/cle_pkg.sv @@
// Shared types and codes for the circular list engine.
// No dependencies; cle_if and the engine refer to it by scoped names, the testbench imports it.
package cle_pkg;

  // Command codes carried on the request channel
  localparam logic [1:0] FUNC_INSERT   = 2'd0;
  localparam logic [1:0] FUNC_DELETE   = 2'd1;
  localparam logic [1:0] FUNC_TRAVERSE = 2'd2;

  // Status codes carried on the result channel
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  localparam int FIELD_WIDTH = 32;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_WALK,
    S_SCAN,
    S_INS_W1,
    S_INS_W2,
    S_DEL_TAIL,
    S_DEL_WALK,
    S_DEL_W1,
    S_DEL_W2,
    S_TRV,
    S_REPLY
  } state_t;

endpackage

@@ hw/rtl/cle_if.sv @@
// Request and result channel interfaces for the circular list engine.
// Depends on cle_pkg for the field width.
interface cle_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            func;
  logic signed [cle_pkg::FIELD_WIDTH-1:0] key;
  logic signed [cle_pkg::FIELD_WIDTH-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface cle_res_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cle_pkg::FIELD_WIDTH-1:0] element;
  logic [1:0]                            status;
  logic                                  last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink   (input valid, input element, input status, input last, output ready);
endinterface

@@ hw/rtl/cle_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/circular_list_engine_top.sv @@
// Circular singly linked list engine: node store walker and command sequencer.
// Depends on cle_pkg, cle_if (cle_cmd_if, cle_res_if) and cle_ram.
//
//   channel  dir  handshake     payload
//   cmd      in   valid/ready   func, key, value
//   res      out  valid/ready   element, status, last
//
// One node store (used bit, value, next link) read once a cycle, with registered read data.
// Insert: key walk from the tail, free scan from index 0, two writes, reply (an empty
//   list skips walk and second write). Delete: tail read, walk, two writes, reply.
// Traverse: one result per cycle while res is ready, one read per node. Commands are
// taken only when idle. After reset a clearing pass wipes the store; cmd.ready stays low.
// A stalled res holds its register; traverse then waits on the same node.
module circular_list_engine_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  cle_cmd_if.sink   cmd,
  cle_res_if.source res
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = cle_pkg::FIELD_WIDTH;

  typedef struct packed {
    logic                  used;
    logic [DATA_WIDTH-1:0] value;
    logic [IW-1:0]         link;
  } node_t;

  localparam int NW = $bits(node_t);

  cle_pkg::state_t state, state_next;
  logic [IW-1:0]         curr, curr_next;
  logic [IW-1:0]         tail, tail_next;
  logic                  nonempty, nonempty_next;
  logic [CW-1:0]         count, count_next;
  logic [IW-1:0]         prev, prev_next;
  logic [DATA_WIDTH-1:0] prev_val, prev_val_next;
  logic [IW-1:0]         found_idx, found_idx_next;
  logic [IW-1:0]         found_link, found_link_next;
  logic                  empty_ins, empty_ins_next;
  logic [DATA_WIDTH-1:0] key_s, key_s_next;
  logic [DATA_WIDTH-1:0] val_s, val_s_next;
  logic [1:0]            rep_status, rep_status_next;
  logic                  out_valid, out_valid_next;
  logic [FW-1:0]         out_element, out_element_next;
  logic [1:0]            out_status, out_status_next;
  logic                  out_last, out_last_next;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  node_t         wr_node;
  logic [NW-1:0] rd_data;
  node_t         rd_node;
  logic          out_free;

  assign rd_node  = node_t'(rd_data);
  assign out_free = !out_valid || res.ready;

  cle_ram #(
    .WIDTH (NW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (NW'(wr_node)),
    .rd_addr (curr_next),
    .rd_data (rd_data)
  );

  assign cmd.ready   = (state == cle_pkg::S_IDLE);
  assign res.valid   = out_valid;
  assign res.element = out_element;
  assign res.status  = out_status;
  assign res.last    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cle_pkg::S_CLEAR;
      curr      <= '0;
      tail      <= '0;
      nonempty  <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      curr      <= curr_next;
      tail      <= tail_next;
      nonempty  <= nonempty_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    prev        <= prev_next;
    prev_val    <= prev_val_next;
    found_idx   <= found_idx_next;
    found_link  <= found_link_next;
    empty_ins   <= empty_ins_next;
    key_s       <= key_s_next;
    val_s       <= val_s_next;
    rep_status  <= rep_status_next;
    out_element <= out_element_next;
    out_status  <= out_status_next;
    out_last    <= out_last_next;
  end

  always_comb begin
    state_next       = state;
    curr_next        = curr;
    tail_next        = tail;
    nonempty_next    = nonempty;
    count_next       = count;
    prev_next        = prev;
    prev_val_next    = prev_val;
    found_idx_next   = found_idx;
    found_link_next  = found_link;
    empty_ins_next   = empty_ins;
    key_s_next       = key_s;
    val_s_next       = val_s;
    rep_status_next  = rep_status;
    out_valid_next   = out_valid && !res.ready;
    out_element_next = out_element;
    out_status_next  = out_status;
    out_last_next    = out_last;
    wr_en            = 1'b0;
    wr_addr          = curr;
    wr_node          = '0;

    case (state)
      cle_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        if (curr == IW'(CAPACITY - 1)) begin
          curr_next  = '0;
          state_next = cle_pkg::S_IDLE;
        end else begin
          curr_next = curr + 1'b1;
        end
      end

      cle_pkg::S_IDLE: begin
        if (cmd.valid) begin
          key_s_next = DATA_WIDTH'(signed'(cmd.key));
          val_s_next = DATA_WIDTH'(signed'(cmd.value));
          case (cmd.func)
            cle_pkg::FUNC_INSERT: begin
              if (nonempty) begin
                curr_next      = tail;
                empty_ins_next = 1'b0;
                state_next     = cle_pkg::S_INS_WALK;
              end else begin
                // empty list: key ignored, go straight to the free scan
                curr_next      = '0;
                empty_ins_next = 1'b1;
                state_next     = cle_pkg::S_SCAN;
              end
            end
            cle_pkg::FUNC_DELETE: begin
              if (nonempty) begin
                curr_next  = tail;
                state_next = cle_pkg::S_DEL_TAIL;
              end else begin
                rep_status_next = cle_pkg::STATUS_EMPTY;
                state_next      = cle_pkg::S_REPLY;
              end
            end
            cle_pkg::FUNC_TRAVERSE: begin
              if (nonempty) begin
                curr_next  = tail;
                state_next = cle_pkg::S_TRV;
              end else begin
                rep_status_next = cle_pkg::STATUS_EMPTY;
                state_next      = cle_pkg::S_REPLY;
              end
            end
            default: begin
            end
          endcase
        end
      end

      cle_pkg::S_INS_WALK: begin
        if (rd_node.value == key_s) begin
          found_idx_next  = curr;
          found_link_next = rd_node.link;
          if (count == CW'(CAPACITY)) begin
            rep_status_next = cle_pkg::STATUS_FULL;
            state_next      = cle_pkg::S_REPLY;
          end else begin
            curr_next  = '0;
            state_next = cle_pkg::S_SCAN;
          end
        end else if (rd_node.link == tail) begin
          rep_status_next = cle_pkg::STATUS_NOT_FOUND;
          state_next      = cle_pkg::S_REPLY;
        end else begin
          curr_next = rd_node.link;
        end
      end

      // lowest free index; count below capacity guarantees a hit
      cle_pkg::S_SCAN: begin
        if (!rd_node.used) begin
          state_next = cle_pkg::S_INS_W1;
        end else begin
          curr_next = curr + 1'b1;
        end
      end

      cle_pkg::S_INS_W1: begin
        wr_en         = 1'b1;
        wr_addr       = curr;
        wr_node.used  = 1'b1;
        wr_node.value = val_s;
        wr_node.link  = empty_ins ? curr : found_link;
        if (empty_ins) begin
          tail_next       = curr;
          nonempty_next   = 1'b1;
          count_next      = count + 1'b1;
          rep_status_next = cle_pkg::STATUS_OK;
          state_next      = cle_pkg::S_REPLY;
        end else begin
          state_next = cle_pkg::S_INS_W2;
        end
      end

      // relink the matched node; its value equals the key
      cle_pkg::S_INS_W2: begin
        wr_en         = 1'b1;
        wr_addr       = found_idx;
        wr_node.used  = 1'b1;
        wr_node.value = key_s;
        wr_node.link  = curr;
        if (found_idx == tail) begin
          tail_next = curr;
        end
        count_next      = count + 1'b1;
        rep_status_next = cle_pkg::STATUS_OK;
        state_next      = cle_pkg::S_REPLY;
      end

      cle_pkg::S_DEL_TAIL: begin
        prev_next     = curr;
        prev_val_next = rd_node.value;
        curr_next     = rd_node.link;
        state_next    = cle_pkg::S_DEL_WALK;
      end

      cle_pkg::S_DEL_WALK: begin
        if (rd_node.value == key_s) begin
          found_link_next = rd_node.link;
          state_next      = cle_pkg::S_DEL_W1;
        end else if (curr == tail) begin
          rep_status_next = cle_pkg::STATUS_NOT_FOUND;
          state_next      = cle_pkg::S_REPLY;
        end else begin
          prev_next     = curr;
          prev_val_next = rd_node.value;
          curr_next     = rd_node.link;
        end
      end

      cle_pkg::S_DEL_W1: begin
        wr_en         = 1'b1;
        wr_addr       = prev;
        wr_node.used  = 1'b1;
        wr_node.value = prev_val;
        wr_node.link  = found_link;
        state_next    = cle_pkg::S_DEL_W2;
      end

      // free the node; for a lone node this overrides the write above
      cle_pkg::S_DEL_W2: begin
        wr_en      = 1'b1;
        wr_addr    = curr;
        count_next = count - 1'b1;
        if (curr == prev) begin
          nonempty_next = 1'b0;
          tail_next     = '0;
        end else if (curr == tail) begin
          tail_next = prev;
        end
        rep_status_next = cle_pkg::STATUS_OK;
        state_next      = cle_pkg::S_REPLY;
      end

      cle_pkg::S_TRV: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_element_next = FW'(signed'(rd_node.value));
          out_status_next  = cle_pkg::STATUS_OK;
          out_last_next    = (rd_node.link == tail);
          if (rd_node.link == tail) begin
            state_next = cle_pkg::S_IDLE;
          end else begin
            curr_next = rd_node.link;
          end
        end
      end

      cle_pkg::S_REPLY: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_element_next = '0;
          out_status_next  = rep_status;
          out_last_next    = 1'b1;
          state_next       = cle_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = cle_pkg::S_IDLE;
      end
    endcase
  end

  // node count and list flag move together
  a_count_flag: assert property (@(posedge clk) disable iff (rst)
    nonempty == (count != '0))
    else $error("node count disagrees with list flag");

  // free scan must not run off the end of the store
  a_scan_hit: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_SCAN && curr == IW'(CAPACITY - 1)) |-> !rd_node.used)
    else $error("free scan found no free node");

  // walks and traversal only ever land on live nodes
  a_walk_live: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_INS_WALK || state == cle_pkg::S_DEL_WALK ||
     state == cle_pkg::S_DEL_TAIL || state == cle_pkg::S_TRV) |-> rd_node.used)
    else $error("list walk read a free node");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_element) && $stable(out_last)))
    else $error("pending result overwritten");

endmodule

@@ tb/list_check_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the circular list engine: a shadow copy of the node store
// predicts the replies of each accepted request. Depends on cle_pkg.
package list_check_pkg;
  import cle_pkg::*;

  localparam int NODES  = 16;
  localparam int LINK_W = $clog2(NODES);

  typedef logic signed [FIELD_WIDTH-1:0] word_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    word_t      element;
    logic [1:0] status;
    logic       last;
  } reply_t;

  class list_scoreboard;
    word_t  node_value[NODES];
    link_t  node_link[NODES];
    bit     node_used[NODES];
    link_t  tail;
    bit     nonempty;
    reply_t pending[$];
    int     errors;

    function new();
      foreach (node_used[i]) node_used[i] = 1'b0;
      tail     = '0;
      nonempty = 1'b0;
      errors   = 0;
    endfunction

    function int lowest_free();
      foreach (node_used[i])
        if (!node_used[i]) return i;
      return -1;
    endfunction

    function logic [1:0] insert_after(word_t key, word_t val);
      link_t walk = tail;
      int    slot;
      if (!nonempty) begin
        slot = lowest_free();
        if (slot < 0) return STATUS_FULL;
        node_value[slot] = val;
        node_link[slot]  = link_t'(slot);
        node_used[slot]  = 1'b1;
        tail             = link_t'(slot);
        nonempty         = 1'b1;
        return STATUS_OK;
      end
      // search starts at the tail itself
      for (int steps = 0; steps < NODES; steps++) begin
        if (node_value[walk] == key) begin
          slot = lowest_free();
          if (slot < 0) return STATUS_FULL;
          node_value[slot] = val;
          node_link[slot]  = node_link[walk];
          node_used[slot]  = 1'b1;
          node_link[walk]  = link_t'(slot);
          if (walk == tail) tail = link_t'(slot);
          return STATUS_OK;
        end
        walk = node_link[walk];
        if (walk == tail) break;
      end
      return STATUS_NOT_FOUND;
    endfunction

    function logic [1:0] unlink(word_t key);
      link_t prev = tail;
      link_t walk;
      if (!nonempty) return STATUS_EMPTY;
      walk = node_link[tail];
      // search starts at the head
      for (int steps = 0; steps < NODES; steps++) begin
        if (node_value[walk] == key) begin
          node_link[prev] = node_link[walk];
          node_used[walk] = 1'b0;
          if (walk == prev) begin
            nonempty = 1'b0;
            tail     = '0;
          end else if (walk == tail) begin
            tail = prev;
          end
          return STATUS_OK;
        end
        if (walk == tail) break;
        prev = walk;
        walk = node_link[walk];
      end
      return STATUS_NOT_FOUND;
    endfunction

    function void note_command(logic [1:0] op, word_t key, word_t val);
      reply_t r;
      link_t  walk;
      r.element = '0;
      r.last    = 1'b1;
      case (op)
        FUNC_INSERT: begin
          r.status = insert_after(key, val);
          pending.push_back(r);
        end
        FUNC_DELETE: begin
          r.status = unlink(key);
          pending.push_back(r);
        end
        FUNC_TRAVERSE: begin
          if (!nonempty) begin
            r.status = STATUS_EMPTY;
            pending.push_back(r);
          end else begin
            walk = tail;
            for (int count = 0; count < NODES; count++) begin
              r.element = node_value[walk];
              r.status  = STATUS_OK;
              r.last    = (node_link[walk] == tail) || (count + 1 == NODES);
              pending.push_back(r);
              if (r.last) break;
              walk = node_link[walk];
            end
          end
        end
        default: ; // unused code: no reply, no change
      endcase
    endfunction

    function void check_reply(word_t element, logic [1:0] status, logic last);
      reply_t want;
      if (pending.size() == 0) begin
        $error("unexpected reply: element %0d status %0d last %0d", element, status, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (element !== want.element) begin
        $error("element: expected %0d, actual %0d", $signed(want.element), element);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the circular list engine testbench: drives requests, takes replies.
// Depends on cle_pkg, cle_if, list_check_pkg and circular_list_engine_top.
module tb_top;
  import cle_pkg::*;
  import list_check_pkg::*;

  localparam word_t MIN_WORD = 32'sh8000_0000;
  localparam word_t MAX_WORD = 32'sh7fff_ffff;

  // func code with no command behind it
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic clk;
  logic rst;

  cle_cmd_if cmd_ch ();
  cle_res_if res_ch ();

  circular_list_engine_top #(
    .CAPACITY   (NODES),
    .DATA_WIDTH (FIELD_WIDTH)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  list_scoreboard board = new();
  word_t          pool[10];
  bit             cmd_rush;
  bit             res_rush;
  int             replies_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("circular_list_engine_top: mismatch");
    $finish;
  end

  task automatic send_command(input logic [1:0] op, input word_t key, input word_t val);
    int gap;
    if ($urandom_range(0, 19) == 0) cmd_rush = !cmd_rush;
    gap = cmd_rush ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func  <= op;
    cmd_ch.key   <= key;
    cmd_ch.value <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_command(op, key, val);
  endtask

  // mostly words from a small pool so that searches hit
  function automatic word_t pick_word();
    if ($urandom_range(0, 4) == 0) return word_t'($urandom);
    return pool[$urandom_range(0, 9)];
  endfunction

  task automatic random_request(input bit grow);
    int         r;
    int         insert_top;
    logic [1:0] op;
    r          = $urandom_range(0, 99);
    insert_top = grow ? 70 : 40;
    if (r < 15) op = FUNC_TRAVERSE;
    else if (r < insert_top) op = FUNC_INSERT;
    else op = FUNC_DELETE;
    if ($urandom_range(0, 39) == 0)
      send_command(FUNC_SPARE, word_t'($urandom), word_t'($urandom));
    send_command(op, pick_word(), pick_word());
  endtask

  // receiver: random stalls, one long hold-off to back the engine up
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) res_rush = !res_rush;
      stall = res_rush ? 0 : $urandom_range(0, 17);
      if (replies_seen == 60) stall = 400;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      board.check_reply(res_ch.element, res_ch.status, res_ch.last);
      replies_seen++;
    end
  end

  initial begin
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.func  = FUNC_INSERT;
    cmd_ch.key   = '0;
    cmd_ch.value = '0;
    pool[0] = MIN_WORD;
    pool[1] = MAX_WORD;
    pool[2] = '0;
    pool[3] = -1;
    for (int i = 4; i < 10; i++) pool[i] = word_t'($urandom);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty list handling and the unused code
    send_command(FUNC_TRAVERSE, '0, '0);
    send_command(FUNC_DELETE, MAX_WORD, '0);
    send_command(FUNC_SPARE, MIN_WORD, MAX_WORD);
    // key ignored on an empty list
    send_command(FUNC_INSERT, word_t'($urandom), MAX_WORD);
    // insert after the tail moves the tail
    send_command(FUNC_INSERT, MAX_WORD, MIN_WORD);
    send_command(FUNC_INSERT, 32'sd12345, -1);
    send_command(FUNC_INSERT, MAX_WORD, '0);
    send_command(FUNC_TRAVERSE, '0, '0);
    send_command(FUNC_DELETE, 32'sd12345, '0);
    // head, then tail
    send_command(FUNC_DELETE, MAX_WORD, '0);
    send_command(FUNC_DELETE, MIN_WORD, '0);
    // fill the store from a single node, one more to see it full
    for (int i = 0; i < NODES; i++) send_command(FUNC_INSERT, '0, word_t'($urandom));
    send_command(FUNC_TRAVERSE, '0, '0);
    // only node removal empties the list
    for (int i = 0; i < NODES; i++) send_command(FUNC_DELETE, board.node_value[board.tail], '0);
    send_command(FUNC_TRAVERSE, '0, '0);

    // grow and shrink phases with random content
    for (int phase = 0; phase < 8; phase++)
      for (int n = 0; n < 50; n++) random_request(phase % 2 == 0);

    cmd_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) begin
      $display("circular_list_engine_top: match");
    end else begin
      $display("circular_list_engine_top: mismatch");
    end
    $finish;
  end

endmodule
